/* hw/rtl/msfr_pkg.sv */
// Shared constants, types and register codes of the multiport frame receiver.
package msfr_pkg;

    // Number of serial ports that keep their own frame state.
    localparam int NUM_PORTS = 5;

    localparam int PORT_W = 3;
    localparam int DATA_W = 8;
    localparam int POS_W  = 9;
    localparam int HCNT_W = 4;
    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Queue between the front and back ends (power of two).
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int APB_W  = 32;

    localparam logic [DATA_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [HCNT_W-1:0] HCNT_RESET = 4'd4;
    localparam logic [DATA_W-1:0] PCNT_RESET = 8'd190;

    // Register word indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_SYNC_BYTE     = 2'd0,
        REG_HEADER_COUNT  = 2'd1,
        REG_PAYLOAD_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] sync_byte;
        logic [HCNT_W-1:0] header_count;
        logic [DATA_W-1:0] payload_count;
    } cfg_t;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [PIDX_W-1:0] idx;
        logic              in_range;
        logic [DATA_W-1:0] data;
    } item_t;

    // One result transfer.
    typedef struct packed {
        logic [PORT_W-1:0] port_out;
        logic [DATA_W-1:0] byte_out;
        logic              kept;
        logic [POS_W-1:0]  position;
        logic              frame_end;
        logic              frame_good;
    } result_t;

endpackage

/* hw/rtl/msfr_front.sv */
// Front end: accepts input bytes and classifies their port.
module msfr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [msfr_pkg::PORT_W-1:0]   in_port,
    input  logic [msfr_pkg::DATA_W-1:0]   in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output msfr_pkg::item_t               out_item
);
    import msfr_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // The stage takes a new byte whenever it is empty or drains this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Decode the port into an array index and a range flag.
    always_comb begin
        item_next.port     = in_port;
        item_next.idx      = PIDX_W'(in_port);
        item_next.in_range = (32'(in_port) < NUM_PORTS);
        item_next.data     = in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/msfr_queue.sv */
// Short queue of classified bytes between the front and back ends.
module msfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  msfr_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output msfr_pkg::item_t   out_item
);
    import msfr_pkg::*;

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/msfr_back.sv */
// Back end: per-port frame tracking, checksum check and the result register.
module msfr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  msfr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  msfr_pkg::item_t     in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output msfr_pkg::result_t   out_result
);
    import msfr_pkg::*;

    logic [POS_W-1:0]  pos_reg [NUM_PORTS];
    logic [DATA_W-1:0] sum_reg [NUM_PORTS];
    logic              valid_reg;
    result_t           result_reg;

    logic [POS_W-1:0]  cur;
    logic [DATA_W-1:0] sum;
    logic [POS_W-1:0]  hdr;
    logic [POS_W-1:0]  ck;
    logic [POS_W-1:0]  pos_next;
    logic [DATA_W-1:0] sum_next;
    result_t           result_next;
    logic              take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Select the state of the byte's port.
    always_comb begin
        cur = '0;
        sum = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (in_item.in_range && (in_item.idx == PIDX_W'(i))) begin
                cur = pos_reg[i];
                sum = sum_reg[i];
            end
        end
    end

    // Classify the byte against the frame layout and work out the new state.
    always_comb begin
        hdr = POS_W'(cfg.header_count);
        ck  = hdr + POS_W'(cfg.payload_count);

        pos_next = '0;
        sum_next = '0;

        result_next.port_out   = in_item.port;
        result_next.byte_out   = in_item.data;
        result_next.kept       = 1'b0;
        result_next.position   = '0;
        result_next.frame_end  = 1'b0;
        result_next.frame_good = 1'b0;

        if (cur < hdr) begin
            // Header byte: it must match the sync value or the hunt restarts.
            if (in_item.data == cfg.sync_byte) begin
                result_next.kept     = 1'b1;
                result_next.position = cur;
                pos_next             = cur + 1'b1;
                sum_next             = sum;
            end
        end else if (cur < ck) begin
            // Payload byte: keep it and add it to the running sum.
            result_next.kept     = 1'b1;
            result_next.position = cur;
            pos_next             = cur + 1'b1;
            sum_next             = sum + in_item.data;
        end else if (cur == ck) begin
            // Checksum byte: the frame ends and the port starts over.
            result_next.kept       = 1'b1;
            result_next.position   = cur;
            result_next.frame_end  = 1'b1;
            result_next.frame_good = (in_item.data == sum);
        end
        // A position left beyond the checksum index restarts the port.

        if (!in_item.in_range) begin
            result_next.kept       = 1'b0;
            result_next.position   = '0;
            result_next.frame_end  = 1'b0;
            result_next.frame_good = 1'b0;
        end
    end

    // Per-port state, written back in the cycle the byte is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else if (take && in_item.in_range) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                if (in_item.idx == PIDX_W'(i)) begin
                    pos_reg[i] <= pos_next;
                    sum_reg[i] <= sum_next;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

/* hw/rtl/multiport_sync_frame_receiver_core.sv */
// Top level of the multiport sync-header frame receiver with additive checksum.
//
// Bytes tagged with their serial port enter on the s_ stream and produce exactly
// one result transfer each on the m_ stream, in order. Each of the ports keeps a
// frame position and an 8-bit running sum: header_count bytes equal to sync_byte
// open a frame, payload_count bytes are kept and summed modulo 256, and the next
// byte is compared with the sum (m_tlast marks it, frame_good reports the match).
// The block sustains one byte per clock cycle while m_tready is held high; that figure is set
// by the per-port read-modify-write of position and sum in the back end. A byte passes
// through the front-end register, the four-entry queue and the result register.
// Registers are to be written over the APB port only while the stream is idle; the block
// itself does not enforce this. A write takes effect on the next byte of every port.
module multiport_sync_frame_receiver_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic [2:0]                    s_tuser,   // [2:0] port

    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [7:0] byte_out, [16:8] position
    output logic [4:0]                    m_tuser,   // [2:0] port_out, [3] kept, [4] frame_good
    output logic                          m_tlast,   // frame_end

    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msfr_pkg::ADDR_W-1:0]   paddr,
    input  logic [msfr_pkg::APB_W-1:0]    pwdata,
    output logic [msfr_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import msfr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    logic     fq_valid;
    logic     fq_ready;
    item_t    fq_item;
    logic     qb_valid;
    logic     qb_ready;
    item_t    qb_item;
    result_t  result;

    // Register file on the APB port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte     <= SYNC_RESET;
            cfg_reg.header_count  <= HCNT_RESET;
            cfg_reg.payload_count <= PCNT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SYNC_BYTE:     cfg_reg.sync_byte     <= pwdata[DATA_W-1:0];
                REG_HEADER_COUNT:  cfg_reg.header_count  <= pwdata[HCNT_W-1:0];
                REG_PAYLOAD_COUNT: cfg_reg.payload_count <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC_BYTE:     prdata = APB_W'(cfg_reg.sync_byte);
            REG_HEADER_COUNT:  prdata = APB_W'(cfg_reg.header_count);
            REG_PAYLOAD_COUNT: prdata = APB_W'(cfg_reg.payload_count);
            default:           prdata = '0;
        endcase
    end

    msfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_port   (s_tuser),
        .in_data   (s_tdata),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    msfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    msfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_item    (qb_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result transfer.
    assign m_tdata = {7'b0, result.position, result.byte_out};
    assign m_tuser = {result.frame_good, result.kept, result.port_out};
    assign m_tlast = result.frame_end;

`ifndef NO_ASSERTIONS
    // The result stream is empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A good frame flag only comes with the checksum byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4]) |-> (m_tlast && m_tuser[3]))
        else $error("frame_good without frame_end");

    // A discarded byte reports position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[3]) |-> (m_tdata[16:8] == 9'd0 && !m_tlast))
        else $error("discarded byte with a position");

    // A kept byte inside the header always equals the sync value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3] && (m_tdata[16:8] < 9'(cfg_reg.header_count)))
        |-> (m_tdata[7:0] == cfg_reg.sync_byte))
        else $error("header byte kept without matching sync value");
`endif

endmodule
